### hdl/nfba_pkg.sv
// ----------------------------------------------------------------------------
// Next-fit bitmap ID allocator: shared definitions
// Field widths, request and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nfba_pkg;

  localparam int CODE_W   = 17;
  localparam int BASE_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic [BASE_W-1:0] DEF_CODE_BASE = 16'd1000;

  localparam int DEF_CAPACITY  = 1024;
  localparam int DEF_CHUNK     = 256;
  localparam int DEF_WORD_BITS = 32;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

endpackage

`default_nettype wire

### hdl/nfba_bitmap.sv
// ----------------------------------------------------------------------------
// Used-slot bitmap store
// One write port and one registered read port over the bitmap words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfba_bitmap #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/nfba_divw.sv
// ----------------------------------------------------------------------------
// Slot splitter
// Splits a slot number into word index and bit offset by a reciprocal
// multiply, a back-multiply and one correction step on a registered estimate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfba_divw #(
  parameter int WORD_BITS = 32,
  parameter int X_W       = 11,
  parameter int Q_W       = 5,
  parameter int B_W       = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [X_W-1:0] x,
  output logic           done,
  output logic [Q_W-1:0] q,
  output logic [B_W-1:0] r,
  output logic [X_W-1:0] ws
);

  localparam int          SH    = X_W;
  localparam int          R_W   = SH + 1;
  localparam int          P_W   = X_W + R_W;
  localparam int unsigned RECIP = (2 ** SH) / WORD_BITS;

  logic [P_W-1:0]   prod_r;
  logic [X_W-1:0]   x1_r;
  logic             v1_r;
  logic [X_W-1:0]   qe_r;
  logic [B_W:0]     re_r;
  logic [X_W-1:0]   x2_r;
  logic             v2_r;

  logic [X_W-1:0]   qe;
  logic [2*X_W-1:0] qm;
  logic [X_W-1:0]   re_full;
  logic             corr;
  logic [B_W:0]     re_adj;
  logic [X_W-1:0]   q_full;

  // The estimate is never above the true quotient and at most one below it.
  assign qe      = X_W'(prod_r >> SH);
  assign qm      = (2*X_W)'(qe) * (2*X_W)'(WORD_BITS);
  assign re_full = x1_r - qm[X_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
    if (start) begin
      x1_r   <= x;
      prod_r <= P_W'(x) * P_W'(RECIP);
    end
    if (v1_r) begin
      qe_r <= qe;
      re_r <= re_full[B_W:0];
      x2_r <= x1_r;
    end
  end

  assign corr   = (re_r >= (B_W+1)'(WORD_BITS));
  assign re_adj = re_r - (B_W+1)'(WORD_BITS);
  assign q_full = qe_r + X_W'(corr);

  assign done = v2_r;
  assign q    = q_full[Q_W-1:0];
  assign r    = corr ? re_adj[B_W-1:0] : re_r[B_W-1:0];
  assign ws   = x2_r - X_W'(r);

endmodule

`default_nettype wire

### hdl/nfba_bitfind.sv
// ----------------------------------------------------------------------------
// Free-bit finder
// Locates the lowest clear bit of a bitmap word among the valid positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nfba_bitfind #(
  parameter int WORD_BITS = 32,
  parameter int BIT_W     = 5
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [WORD_BITS-1:0] valid,
  output logic                 found,
  output logic [BIT_W-1:0]     idx
);

  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] lowest;

  // Isolating the lowest set bit of the free mask leaves a one-hot word.
  assign free_bits = valid & ~word;
  assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));
  assign found     = |free_bits;

  always_comb begin
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      idx = idx | (lowest[i] ? BIT_W'(i) : '0);
    end
  end

endmodule

`default_nettype wire

### hdl/next_fit_bitmap_id_allocator_unit.sv
// ----------------------------------------------------------------------------
// Next-fit bitmap ID allocator
// Grants and releases identifier codes from a used-slot bitmap.
// ----------------------------------------------------------------------------
// An allocate first tries the slot after the last grant, then scans the
// bitmap one word per cycle from that slot's word to the end of the opened
// region and wraps to the start; with no free slot it opens a further chunk
// (clearing the chunk's words one per cycle) up to the capacity, otherwise
// it reports no free slot. When the slot after the last grant lies outside
// the opened region the scan starts at once from word 0. A release and an
// allocate that gets the slot after the last grant pass through the slot
// splitter, the registered bitmap read and the check state; an ignored
// release goes straight to the result. A scan issues each bitmap read one
// word ahead of checking the returned data, and opening a chunk adds a
// split and a read of the new word and then the clearing of the chunk.
// The block takes one transaction at a time; the result sits in an output
// register so the next request may be accepted before it is taken, and a
// result that finds that register still full waits until it is emptied.
`timescale 1ns / 1ps
`default_nettype none

module next_fit_bitmap_id_allocator_unit #(
  parameter int CAPACITY  = nfba_pkg::DEF_CAPACITY,
  parameter int CHUNK     = nfba_pkg::DEF_CHUNK,
  parameter int WORD_BITS = nfba_pkg::DEF_WORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [nfba_pkg::BASE_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [nfba_pkg::CODE_W-1:0]   in_release_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nfba_pkg::CODE_W-1:0]   out_granted_code,
  output logic [nfba_pkg::STATUS_W-1:0] out_status
);

  import nfba_pkg::*;

  localparam int NWORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int IDX_W  = $clog2(NWORDS);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int SLOT_W = $clog2(CAPACITY + 1);
  localparam int WS_W   = $clog2(CAPACITY + 2 * WORD_BITS);
  localparam int LIM_W  = $clog2(CAPACITY + CHUNK + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_RD, S_CHK, S_SCAN, S_WR, S_CLR, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_REL, OP_TRY, OP_EXP
  } op_t;

  state_t                st_r;
  op_t                   op_r;
  logic [IDX_W-1:0]      word_r;
  logic [BIT_W-1:0]      bit_r;
  logic [WS_W-1:0]       ws_r;
  logic [WORD_BITS-1:0]  data_r;
  logic [IDX_W-1:0]      iw_r;
  logic [WS_W-1:0]       iws_r;
  logic [IDX_W-1:0]      ini_r;
  logic                  phase_r;
  logic                  pend_r;
  logic [IDX_W-1:0]      pw_r;
  logic [WS_W-1:0]       pws_r;
  logic [SLOT_W-1:0]     next_slot_r;
  logic [SLOT_W-1:0]     open_limit_r;
  logic [BASE_W-1:0]     base_r;
  logic [CODE_W-1:0]     res_code_r;
  logic [STATUS_W-1:0]   res_status_r;
  logic                  out_valid_r;
  logic [CODE_W-1:0]     out_code_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic [CODE_W:0]       rel_diff;
  logic                  rel_bad;
  logic                  div_start;
  logic [SLOT_W-1:0]     div_x;
  logic                  div_done;
  logic [IDX_W-1:0]      div_q;
  logic [BIT_W-1:0]      div_r;
  logic [SLOT_W-1:0]     div_ws;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [WORD_BITS-1:0]  mem_rdata;
  logic [WORD_BITS-1:0]  bit_oh;
  logic [WORD_BITS-1:0]  chk_md;
  logic [WORD_BITS-1:0]  scan_mask;
  logic [WORD_BITS-1:0]  scan_md;
  logic                  find_any;
  logic [BIT_W-1:0]      find_idx;
  logic                  found_now;
  logic                  issue_ok;
  logic                  scan_over;
  logic                  room;
  logic [SLOT_W-1:0]     chk_slot;
  logic [SLOT_W-1:0]     wr_slot;

  // Bits at or above the opened limit are never trusted: words past the
  // limit are not cleared at reset, only when their chunk is opened.
  function automatic logic [WORD_BITS-1:0] valid_mask(input logic [WS_W-1:0] ws,
                                                      input logic [SLOT_W-1:0] lim);
    logic [WS_W-1:0]      limx;
    logic [WS_W-1:0]      rem;
    logic [WORD_BITS-1:0] m;
    limx = WS_W'(lim);
    rem  = (limx > ws) ? (limx - ws) : '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      m[b] = (WS_W'(b) < rem);
    end
    return m;
  endfunction

  function automatic logic [CODE_W-1:0] make_code(input logic [BASE_W-1:0] base,
                                                  input logic [SLOT_W-1:0] slot);
    return CODE_W'(base) + CODE_W'(slot);
  endfunction

  assign rel_diff = {1'b0, in_release_code} - (CODE_W+1)'(base_r);
  assign rel_bad  = rel_diff[CODE_W] || (rel_diff[CODE_W-1:0] >= CODE_W'(open_limit_r));

  assign bit_oh    = WORD_BITS'(1) << bit_r;
  assign chk_md    = mem_rdata & valid_mask(ws_r, open_limit_r);
  assign scan_mask = valid_mask(pws_r, open_limit_r);
  assign scan_md   = mem_rdata & scan_mask;
  assign chk_slot  = SLOT_W'(ws_r + WS_W'(bit_r));
  assign wr_slot   = chk_slot;

  assign found_now = pend_r && find_any;
  assign issue_ok  = phase_r ? (iw_r < ini_r) : (iws_r < WS_W'(open_limit_r));
  assign scan_over = !found_now && !issue_ok && (phase_r || (ini_r == '0));
  assign room      = (LIM_W'(open_limit_r) + LIM_W'(CHUNK)) <= LIM_W'(CAPACITY);

  always_comb begin
    div_start = 1'b0;
    div_x     = open_limit_r;
    if (st_r == S_IDLE && in_valid) begin
      if (in_req_type == REQ_RELEASE) begin
        div_start = !rel_bad;
        div_x     = SLOT_W'(rel_diff[CODE_W-1:0]);
      end else begin
        div_start = (next_slot_r < open_limit_r);
        div_x     = next_slot_r;
      end
    end else if (st_r == S_SCAN) begin
      div_start = scan_over && room;
    end
  end

  assign mem_raddr = (st_r == S_RD) ? word_r : iw_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_r;
    mem_wdata = chk_md | bit_oh;
    unique case (st_r)
      S_CHK: begin
        unique case (op_r)
          OP_REL: begin
            mem_we    = 1'b1;
            mem_wdata = chk_md & ~bit_oh;
          end
          OP_TRY: mem_we = !chk_md[bit_r];
          OP_EXP: mem_we = 1'b1;
        endcase
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_wdata = data_r | bit_oh;
      end
      S_CLR: begin
        mem_we    = (iws_r < WS_W'(open_limit_r));
        mem_waddr = iw_r;
        mem_wdata = '0;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      op_r         <= OP_REL;
      next_slot_r  <= '0;
      open_limit_r <= '0;
      base_r       <= DEF_CODE_BASE;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
      phase_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      // In S_DONE the output register is handled by the state itself.
      if (out_valid_r && out_ready && st_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_req_type == REQ_RELEASE) begin
              if (rel_bad) begin
                res_code_r   <= '0;
                res_status_r <= STATUS_IGNORED;
                st_r         <= S_DONE;
              end else begin
                op_r <= OP_REL;
                st_r <= S_DIV;
              end
            end else if (next_slot_r < open_limit_r) begin
              op_r <= OP_TRY;
              st_r <= S_DIV;
            end else begin
              iw_r    <= '0;
              iws_r   <= '0;
              ini_r   <= '0;
              phase_r <= 1'b0;
              pend_r  <= 1'b0;
              st_r    <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            word_r <= div_q;
            bit_r  <= div_r;
            ws_r   <= WS_W'(div_ws);
            st_r   <= S_RD;
          end
        end
        S_RD: st_r <= S_CHK;
        S_CHK: begin
          unique case (op_r)
            OP_REL: begin
              res_code_r   <= '0;
              res_status_r <= STATUS_OK;
              st_r         <= S_DONE;
            end
            OP_TRY: begin
              if (!chk_md[bit_r]) begin
                res_code_r   <= make_code(base_r, chk_slot);
                res_status_r <= STATUS_OK;
                next_slot_r  <= chk_slot + SLOT_W'(1);
                st_r         <= S_DONE;
              end else begin
                ini_r   <= word_r;
                iw_r    <= word_r;
                iws_r   <= ws_r;
                phase_r <= 1'b0;
                pend_r  <= 1'b0;
                st_r    <= S_SCAN;
              end
            end
            OP_EXP: begin
              res_code_r   <= make_code(base_r, chk_slot);
              res_status_r <= STATUS_OK;
              next_slot_r  <= chk_slot + SLOT_W'(1);
              open_limit_r <= SLOT_W'(LIM_W'(open_limit_r) + LIM_W'(CHUNK));
              iw_r         <= word_r + IDX_W'(1);
              iws_r        <= ws_r + WS_W'(WORD_BITS);
              st_r         <= S_CLR;
            end
          endcase
        end
        S_SCAN: begin
          // Reads are issued one word ahead of the check of returned data.
          if (found_now) begin
            word_r <= pw_r;
            ws_r   <= pws_r;
            bit_r  <= find_idx;
            data_r <= scan_md;
            pend_r <= 1'b0;
            st_r   <= S_WR;
          end else if (issue_ok) begin
            pend_r <= 1'b1;
            pw_r   <= iw_r;
            pws_r  <= iws_r;
            iw_r   <= iw_r + IDX_W'(1);
            iws_r  <= iws_r + WS_W'(WORD_BITS);
          end else if (!scan_over) begin
            phase_r <= 1'b1;
            iw_r    <= '0;
            iws_r   <= '0;
            pend_r  <= 1'b0;
          end else if (!room) begin
            pend_r       <= 1'b0;
            res_code_r   <= '0;
            res_status_r <= STATUS_FULL;
            st_r         <= S_DONE;
          end else begin
            pend_r <= 1'b0;
            op_r   <= OP_EXP;
            st_r   <= S_DIV;
          end
        end
        S_WR: begin
          res_code_r   <= make_code(base_r, wr_slot);
          res_status_r <= STATUS_OK;
          next_slot_r  <= wr_slot + SLOT_W'(1);
          st_r         <= S_DONE;
        end
        S_CLR: begin
          if (iws_r < WS_W'(open_limit_r)) begin
            iw_r  <= iw_r + IDX_W'(1);
            iws_r <= iws_r + WS_W'(WORD_BITS);
          end else begin
            st_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_code_r   <= res_code_r;
            out_status_r <= res_status_r;
            st_r         <= S_IDLE;
          end
        end
      endcase
    end
  end

  nfba_divw #(
    .WORD_BITS (WORD_BITS),
    .X_W       (SLOT_W),
    .Q_W       (IDX_W),
    .B_W       (BIT_W)
  ) u_divw (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .x     (div_x),
    .done  (div_done),
    .q     (div_q),
    .r     (div_r),
    .ws    (div_ws)
  );

  nfba_bitmap #(
    .DEPTH  (NWORDS),
    .ADDR_W (IDX_W),
    .DATA_W (WORD_BITS)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  nfba_bitfind #(
    .WORD_BITS (WORD_BITS),
    .BIT_W     (BIT_W)
  ) u_bitfind (
    .word  (mem_rdata),
    .valid (scan_mask),
    .found (find_any),
    .idx   (find_idx)
  );

  assign in_ready         = (st_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_granted_code = out_code_r;
  assign out_status       = out_status_r;

  a_code_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STATUS_OK) |-> (out_code_r == '0))
    else $error("granted code not zero on a failed transaction");

  a_next_within_region: assert property (@(posedge clk) disable iff (!rst_n)
    next_slot_r <= open_limit_r)
    else $error("next slot beyond the opened region");

  a_limit_within_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    LIM_W'(open_limit_r) <= LIM_W'(CAPACITY))
    else $error("opened region exceeds capacity");

  a_split_only_when_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == S_DIV))
    else $error("slot splitter finished outside its wait state");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (st_r == S_CHK || st_r == S_WR || st_r == S_CLR))
    else $error("bitmap written outside an update state");

endmodule

`default_nettype wire
